// ===== src/e2g_pkg.sv =====
// Shared types and constants for the ECEF to geodetic converter.
// Holds the request and response structs of the shared arithmetic unit, the
// WGS84 constants and the CORDIC arctangent table. No dependencies.
package e2g_pkg;

    localparam int CORDIC_N = 62;

    // Shared unit operations.
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_ATAN
    } e2g_op_t;

    typedef struct packed {
        logic          start;
        e2g_op_t       op;
        logic [127:0]  a;
        logic [63:0]   b;
    } e2g_req_t;

    typedef struct packed {
        logic          done;
        logic [127:0]  res;
    } e2g_rsp_t;

    // Configuration register indexes.
    localparam logic REG_HEIGHT_TOL = 1'b0;
    localparam logic REG_MAX_ITER   = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_POLAR     = 2'd1;
    localparam logic [1:0] STATUS_CAP       = 2'd2;

    // Semi-major axis in 1/1024 m, pi and 1/pi in fixed point.
    localparam logic [63:0] A_UNITS    = 64'd6531212288;
    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

    // Flattening and first eccentricity squared, Q62.
    localparam logic [127:0] F_Q62    = (128'd1000000000 << 62) / 128'd298257223563;
    localparam logic [127:0] ECC_PROD = F_Q62 * ((128'd1 << 63) - F_Q62);
    localparam logic [63:0]  ECC_Q62  = 64'((ECC_PROD + (128'd1 << 61)) >> 62);

    typedef logic [CORDIC_N-1:0][63:0] atan_tab_t;

    // Arctangent of 2^-i in radians Q60, from the alternating series.
    function automatic atan_tab_t atan_table();
        atan_tab_t   t;
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        t[0] = (PI_Q60 + 64'd2) >> 2;
        for (int i = 1; i < CORDIC_N; i++) begin
            sum = '0;
            k = 0;
            while (i * (2 * k + 1) <= 62) begin
                term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
                sum = (k % 2 == 1) ? sum - term : sum + term;
                k++;
            end
            t[i] = (sum + 64'd2) >> 2;
        end
        return t;
    endfunction

    localparam atan_tab_t ATAN_TAB = atan_table();

endpackage

// ===== src/e2g_unit.sv =====
// Shared multi-cycle arithmetic unit: 64x64 multiply, 128/64 divide,
// 128-bit square root and CORDIC vectoring arctangent.
// Depends on e2g_pkg.
module e2g_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  e2g_pkg::e2g_req_t  req,
    output e2g_pkg::e2g_rsp_t  rsp
);
    import e2g_pkg::*;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_DIV,
        U_SQRT,
        U_NORM,
        U_ROT
    } ustate_t;

    ustate_t             state_reg;
    logic                done_reg;
    logic [127:0]        res_reg;
    logic [127:0]        acc_reg;
    logic [63:0]         a_reg;
    logic [63:0]         b_reg;
    logic [66:0]         rem_reg;
    logic [63:0]         quo_reg;
    logic [6:0]          cnt_reg;
    logic signed [63:0]  cx_reg;
    logic signed [63:0]  cy_reg;
    logic signed [63:0]  ang_reg;

    // Multiply: one 32x32 partial product per cycle.
    logic [31:0]  a_half;
    logic [31:0]  b_half;
    logic [63:0]  pp;
    logic [1:0]   pp_sel;
    logic [127:0] pp_sh;
    logic [127:0] mul_sum;

    // Divide and square root: one quotient or root bit per cycle.
    logic [64:0]  div_rs;
    logic         div_ge;
    logic [64:0]  div_rem;
    logic [66:0]  sq_rs;
    logic [66:0]  sq_trial;
    logic         sq_ge;
    logic [66:0]  sq_rem;

    // CORDIC datapath.
    logic [63:0]         uy_abs;
    logic [63:0]         mag_or;
    logic [5:0]          sh;
    logic signed [63:0]  dx;
    logic signed [63:0]  dy;
    logic signed [63:0]  atan_i;
    logic signed [63:0]  ang_new;

    always_comb
    begin
        a_half  = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_half  = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp      = a_half * b_half;
        pp_sel  = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
        pp_sh   = {64'd0, pp} << {pp_sel, 5'd0};
        mul_sum = acc_reg + pp_sh;

        div_rs  = {rem_reg[63:0], acc_reg[127]};
        div_ge  = div_rs >= {1'b0, b_reg};
        div_rem = div_ge ? div_rs - {1'b0, b_reg} : div_rs;

        sq_rs    = {rem_reg[64:0], acc_reg[127:126]};
        sq_trial = {1'b0, quo_reg, 2'b01};
        sq_ge    = sq_rs >= sq_trial;
        sq_rem   = sq_ge ? sq_rs - sq_trial : sq_rs;

        uy_abs  = cy_reg[63] ? 64'(-cy_reg) : 64'(cy_reg);
        mag_or  = 64'(cx_reg) | uy_abs;
        sh      = cnt_reg[5:0];
        dx      = cy_reg >>> sh;
        dy      = cx_reg >>> sh;
        atan_i  = $signed(ATAN_TAB[sh]);
        ang_new = cy_reg[63] ? ang_reg - atan_i : ang_reg + atan_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        cnt_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        unique case (req.op)
                            OP_MUL:
                            begin
                                a_reg     <= req.a[63:0];
                                b_reg     <= req.b;
                                acc_reg   <= '0;
                                state_reg <= U_MUL;
                            end
                            OP_DIV:
                            begin
                                acc_reg   <= req.a;
                                b_reg     <= req.b;
                                state_reg <= U_DIV;
                            end
                            OP_SQRT:
                            begin
                                acc_reg   <= req.a;
                                state_reg <= U_SQRT;
                            end
                            OP_ATAN:
                            begin
                                cx_reg  <= $signed(req.a[63:0]);
                                cy_reg  <= $signed(req.b);
                                ang_reg <= '0;
                                if (req.a[63:0] == 64'd0 && req.b == 64'd0)
                                begin
                                    res_reg  <= '0;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= U_NORM;
                                end
                            end
                            default:
                            begin
                                state_reg <= U_IDLE;
                            end
                        endcase
                    end
                end
                U_MUL:
                begin
                    acc_reg <= mul_sum;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd3)
                    begin
                        res_reg   <= mul_sum;
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                U_DIV:
                begin
                    rem_reg <= {3'd0, div_rem[63:0]};
                    quo_reg <= {quo_reg[62:0], div_ge};
                    acc_reg <= acc_reg << 1;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd127)
                    begin
                        res_reg   <= {64'd0, quo_reg[62:0], div_ge};
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                U_SQRT:
                begin
                    rem_reg <= sq_rem;
                    quo_reg <= {quo_reg[62:0], sq_ge};
                    acc_reg <= acc_reg << 2;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd63)
                    begin
                        res_reg   <= {64'd0, quo_reg[62:0], sq_ge};
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                U_NORM:
                begin
                    if (mag_or[63:58] == 6'd0)
                    begin
                        cx_reg <= cx_reg <<< 1;
                        cy_reg <= cy_reg <<< 1;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= U_ROT;
                    end
                end
                U_ROT:
                begin
                    if (!cy_reg[63])
                    begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                    end
                    else
                    begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                    end
                    ang_reg <= ang_new;
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'(CORDIC_N - 1))
                    begin
                        res_reg   <= {{64{ang_new[63]}}, ang_new};
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res  = res_reg;

endmodule

// ===== src/ecef_to_geodetic.sv =====
// Top level of the ECEF to WGS84 geodetic converter: command port,
// configuration registers and the sequencer that drives the shared unit.
// Depends on e2g_pkg and e2g_unit.
//
// A transaction is accepted on a rising edge with start high and busy low;
// ecef_x, ecef_y and ecef_z are captured then and may change afterwards.
// The block stays busy until the result transaction, which is shown for
// exactly one cycle with done high: latitude, longitude, height and status.
// The receiver cannot stall, so catch the result on that cycle. A transaction
// runs latitude passes, from 1 up to the iteration cap. A point at longitude
// 180 skips the second arctangent. A point on the polar axis gives its result
// without any latitude pass or arctangent. The shared unit does every multiply
// in four 32x32 steps, every divide one quotient bit per cycle and every square
// root one root bit per cycle. Each pass needs three divides, two roots, nine
// multiplies and one convergence check. The two CORDIC arctangents at the end
// each run their normalization shifts before the rotations.
// Configuration writes take effect at once and are meant for idle periods.
module ecef_to_geodetic #(
    parameter int MAX_ITER_LIMIT = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [36:0]  ecef_x,
    input  logic signed [36:0]  ecef_y,
    input  logic signed [36:0]  ecef_z,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [9:0]          cfg_data,
    output logic                done,
    output logic signed [31:0]  latitude,
    output logic signed [31:0]  longitude,
    output logic signed [36:0]  height,
    output logic [1:0]          status
);
    import e2g_pkg::*;

    localparam int K_W  = $clog2(MAX_ITER_LIMIT + 1);
    localparam int CW   = (K_W > 5) ? K_W : 5;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQRTP, S_Q0,
        S_RZ, S_RQ, S_RS, S_C, S_US, S_S2, S_WSQ, S_W, S_N,
        S_PC, S_ZS, S_AW, S_EN, S_QN, S_CHK,
        S_LAT, S_LATU, S_LONC, S_LONA, S_LONU, S_OUT
    } state_t;

    state_t              state_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                op_wait_reg;
    logic [9:0]          tol_reg;
    logic [4:0]          maxit_reg;
    logic signed [36:0]  x_reg;
    logic signed [36:0]  y_reg;
    logic signed [36:0]  z_reg;
    logic [127:0]        acc_reg;
    logic [63:0]         p_reg;
    logic [63:0]         q_reg;
    logic [63:0]         r_reg;
    logic [63:0]         c_reg;
    logic [63:0]         us_reg;
    logic [63:0]         w_reg;
    logic [63:0]         n_reg;
    logic [63:0]         t_reg;
    logic signed [63:0]  h_reg;
    logic signed [63:0]  hprev_reg;
    logic [K_W-1:0]      k_reg;
    logic [K_W-1:0]      cap_reg;
    logic signed [31:0]  lat_reg;
    logic signed [31:0]  lon_reg;
    logic signed [36:0]  height_reg;
    logic [1:0]          status_reg;

    e2g_req_t req;
    e2g_rsp_t rsp;

    e2g_unit u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Product rounded to nearest and scaled down by 2^62, saturating.
    function automatic logic [63:0] rsh62(input logic [127:0] prod);
        logic [127:0] s;
        s = prod + (128'd1 << 61);
        return (s[127:126] != 2'b00) ? '1 : s[125:62];
    endfunction

    // Angle magnitude times 2^64/pi, rounded and scaled to 180/2^31 degree.
    function automatic logic [34:0] to_units(input logic [127:0] prod);
        logic [127:0] s;
        s = prod + (128'd1 << 92);
        return s[127:93];
    endfunction

    function automatic logic [36:0] mag37(input logic signed [36:0] v);
        return v[36] ? 37'(-v) : 37'(v);
    endfunction

    logic [36:0]         ux;
    logic [36:0]         uy;
    logic [36:0]         uz;
    logic [63:0]         ux64;
    logic [63:0]         uy64;
    logic [63:0]         uz64;
    logic signed [63:0]  xp;
    logic [63:0]         t_abs;
    logic [63:0]         prod_sh;
    logic [63:0]         qv;
    logic signed [63:0]  hd;
    logic [63:0]         habs;
    logic [34:0]         umag;
    logic [34:0]         lat_mag;
    logic [CW-1:0]       cap_w;

    always_comb
    begin
        ux      = mag37(x_reg);
        uy      = mag37(y_reg);
        uz      = mag37(z_reg);
        ux64    = 64'(ux);
        uy64    = 64'(uy);
        uz64    = 64'(uz);
        xp      = 64'(x_reg) + $signed(p_reg);
        t_abs   = t_reg[63] ? 64'(-$signed(t_reg)) : t_reg;
        prod_sh = rsh62(rsp.res);
        qv      = p_reg - prod_sh;
        hd      = h_reg - hprev_reg;
        habs    = hd[63] ? 64'(-hd) : 64'(hd);
        umag    = to_units(rsp.res);
        lat_mag = (umag > 35'd1073741824) ? 35'd1073741824 : umag;
        cap_w   = CW'(maxit_reg);
        if (cap_w == '0)
        begin
            cap_w = CW'(1);
        end
        if (cap_w > CW'(MAX_ITER_LIMIT))
        begin
            cap_w = CW'(MAX_ITER_LIMIT);
        end
    end

    // Operation and operands for the shared unit in each step.
    always_comb
    begin
        req.start = 1'b0;
        req.op    = OP_MUL;
        req.a     = '0;
        req.b     = '0;
        unique case (state_reg)
            S_SQX:   begin req.a = 128'(ux64);  req.b = ux64;    end
            S_SQY:   begin req.a = 128'(uy64);  req.b = uy64;    end
            S_SQRTP: begin req.op = OP_SQRT; req.a = acc_reg; end
            S_Q0:    begin req.a = 128'(p_reg); req.b = ECC_Q62; end
            S_RZ:    begin req.a = 128'(uz64);  req.b = uz64;    end
            S_RQ:    begin req.a = 128'(q_reg); req.b = q_reg;   end
            S_RS:    begin req.op = OP_SQRT; req.a = acc_reg; end
            S_C:
            begin
                req.op = OP_DIV;
                req.a  = 128'(q_reg) << 62;
                req.b  = r_reg;
            end
            S_US:
            begin
                req.op = OP_DIV;
                req.a  = 128'(uz64) << 62;
                req.b  = r_reg;
            end
            S_S2:    begin req.a = 128'(us_reg);  req.b = us_reg; end
            S_WSQ:   begin req.a = 128'(ECC_Q62); req.b = t_reg;  end
            S_W:     begin req.op = OP_SQRT; req.a = 128'(t_reg) << 62; end
            S_N:
            begin
                req.op = OP_DIV;
                req.a  = 128'(A_UNITS) << 62;
                req.b  = w_reg;
            end
            S_PC:    begin req.a = 128'(p_reg);   req.b = c_reg;  end
            S_ZS:    begin req.a = 128'(uz64);    req.b = us_reg; end
            S_AW:    begin req.a = 128'(A_UNITS); req.b = w_reg;  end
            S_EN:    begin req.a = 128'(ECC_Q62); req.b = n_reg;  end
            S_QN:    begin req.a = 128'(t_reg);   req.b = c_reg;  end
            S_LAT:
            begin
                req.op = OP_ATAN;
                req.a  = 128'(q_reg);
                req.b  = 64'(z_reg);
            end
            S_LATU:  begin req.a = 128'(t_abs); req.b = INV_PI_Q64; end
            S_LONA:
            begin
                req.op = OP_ATAN;
                req.a  = 128'(64'(xp));
                req.b  = 64'(y_reg);
            end
            S_LONU:  begin req.a = 128'(t_abs); req.b = INV_PI_Q64; end
            default: begin req.op = OP_MUL; end
        endcase
        unique case (state_reg) inside
            S_IDLE, S_CHK, S_LONC, S_OUT: req.start = 1'b0;
            default:                      req.start = !op_wait_reg;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= 10'd1;
            maxit_reg <= 5'd10;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEIGHT_TOL: tol_reg   <= cfg_data;
                REG_MAX_ITER:   maxit_reg <= cfg_data[4:0];
                default:        tol_reg   <= tol_reg;
            endcase
        end
    end

    // Sequencer: each arithmetic step launches one unit operation, waits for
    // its completion and stores the result before moving on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            op_wait_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_wait_reg <= 1'b1;
            end
            if (rsp.done)
            begin
                op_wait_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && !busy_reg)
                    begin
                        x_reg     <= ecef_x;
                        y_reg     <= ecef_y;
                        z_reg     <= ecef_z;
                        cap_reg   <= K_W'(cap_w);
                        busy_reg  <= 1'b1;
                        state_reg <= S_SQX;
                    end
                end
                S_SQX:
                begin
                    if (rsp.done) begin acc_reg <= rsp.res; state_reg <= S_SQY; end
                end
                S_SQY:
                begin
                    if (rsp.done)
                    begin
                        acc_reg   <= acc_reg + rsp.res;
                        state_reg <= S_SQRTP;
                    end
                end
                S_SQRTP:
                begin
                    if (rsp.done)
                    begin
                        p_reg <= rsp.res[63:0];
                        if (rsp.res[63:0] == 64'd0)
                        begin
                            // On the polar axis latitude, longitude and height read as zero.
                            lat_reg    <= '0;
                            lon_reg    <= '0;
                            h_reg      <= '0;
                            status_reg <= STATUS_POLAR;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_Q0;
                        end
                    end
                end
                S_Q0:
                begin
                    if (rsp.done)
                    begin
                        q_reg     <= (qv[63] || qv == 64'd0) ? 64'd1 : qv;
                        k_reg     <= K_W'(1);
                        hprev_reg <= '0;
                        state_reg <= S_RZ;
                    end
                end
                S_RZ:
                begin
                    if (rsp.done) begin acc_reg <= rsp.res; state_reg <= S_RQ; end
                end
                S_RQ:
                begin
                    if (rsp.done)
                    begin
                        acc_reg   <= acc_reg + rsp.res;
                        state_reg <= S_RS;
                    end
                end
                S_RS:
                begin
                    if (rsp.done) begin r_reg <= rsp.res[63:0]; state_reg <= S_C; end
                end
                S_C:
                begin
                    if (rsp.done) begin c_reg <= rsp.res[63:0]; state_reg <= S_US; end
                end
                S_US:
                begin
                    if (rsp.done) begin us_reg <= rsp.res[63:0]; state_reg <= S_S2; end
                end
                S_S2:
                begin
                    if (rsp.done) begin t_reg <= prod_sh; state_reg <= S_WSQ; end
                end
                S_WSQ:
                begin
                    if (rsp.done)
                    begin
                        t_reg     <= (64'd1 << 62) - prod_sh;
                        state_reg <= S_W;
                    end
                end
                S_W:
                begin
                    if (rsp.done) begin w_reg <= rsp.res[63:0]; state_reg <= S_N; end
                end
                S_N:
                begin
                    if (rsp.done) begin n_reg <= rsp.res[63:0]; state_reg <= S_PC; end
                end
                S_PC:
                begin
                    if (rsp.done) begin h_reg <= $signed(prod_sh); state_reg <= S_ZS; end
                end
                S_ZS:
                begin
                    if (rsp.done)
                    begin
                        h_reg     <= h_reg + $signed(prod_sh);
                        state_reg <= S_AW;
                    end
                end
                S_AW:
                begin
                    if (rsp.done)
                    begin
                        h_reg     <= h_reg - $signed(prod_sh);
                        state_reg <= S_EN;
                    end
                end
                S_EN:
                begin
                    if (rsp.done) begin t_reg <= prod_sh; state_reg <= S_QN; end
                end
                S_QN:
                begin
                    if (rsp.done)
                    begin
                        // A denominator below one is held at one.
                        q_reg     <= (qv[63] || qv == 64'd0) ? 64'd1 : qv;
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (habs <= 64'(tol_reg))
                    begin
                        status_reg <= STATUS_CONVERGED;
                        state_reg  <= S_LAT;
                    end
                    else if (k_reg == cap_reg)
                    begin
                        status_reg <= STATUS_CAP;
                        state_reg  <= S_LAT;
                    end
                    else
                    begin
                        hprev_reg <= h_reg;
                        k_reg     <= k_reg + K_W'(1);
                        state_reg <= S_RZ;
                    end
                end
                S_LAT:
                begin
                    if (rsp.done) begin t_reg <= rsp.res[63:0]; state_reg <= S_LATU; end
                end
                S_LATU:
                begin
                    if (rsp.done)
                    begin
                        lat_reg   <= t_reg[63] ? 32'(-lat_mag) : 32'(lat_mag);
                        state_reg <= S_LONC;
                    end
                end
                S_LONC:
                begin
                    // Exactly 180 degrees: the half-angle form has no denominator.
                    if (xp == 64'sd0)
                    begin
                        lon_reg   <= 32'sh8000_0000;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_LONA;
                    end
                end
                S_LONA:
                begin
                    if (rsp.done)
                    begin
                        t_reg     <= {rsp.res[62:0], 1'b0};
                        state_reg <= S_LONU;
                    end
                end
                S_LONU:
                begin
                    if (rsp.done)
                    begin
                        lon_reg   <= t_reg[63] ? 32'(-umag) : 32'(umag);
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (h_reg > 64'sd68719476735)
                    begin
                        height_reg <= 37'h0F_FFFF_FFFF;
                    end
                    else if (h_reg < -64'sd68719476736)
                    begin
                        height_reg <= 37'h10_0000_0000;
                    end
                    else
                    begin
                        height_reg <= h_reg[36:0];
                    end
                    done_reg  <= 1'b1;
                    busy_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign latitude  = lat_reg;
    assign longitude = lon_reg;
    assign height    = height_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_unit_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> op_wait_reg)
        else $error("shared unit finished an operation that was not launched");

    a_pass_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (k_reg != '0 && k_reg <= cap_reg))
        else $error("pass counter outside the iteration cap");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("more than one result for one transaction");

    a_polar_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_POLAR) |->
            (lat_reg == '0 && lon_reg == '0 && height_reg == '0))
        else $error("polar axis result is not all zero");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (status_reg == STATUS_CONVERGED || status_reg == STATUS_POLAR
                      || status_reg == STATUS_CAP))
        else $error("undefined status code on a result");
`endif

endmodule
